/* rtl/rfte_pkg.sv */
// shared types and constants of the relocation fixup table encoder
package rfte_pkg;

	localparam logic FUNC_RELOC = 1'b0;
	localparam logic FUNC_END   = 1'b1;

	localparam logic [7:0] TYPE_NONE  = 8'd0;
	localparam logic [7:0] TYPE_ABS32 = 8'd1;
	localparam logic [7:0] TYPE_PC32  = 8'd4;
	localparam logic [7:0] TYPE_PC16  = 8'd5;
	localparam logic [7:0] TYPE_PC8   = 8'd6;

	localparam logic [31:0] STEP_SIZE = 32'd254;

	// (d - 1) / 254 == ((d - 1) >> 1) / 127 == (y * RECIP_M) >> RECIP_SHIFT for 31-bit y
	localparam logic [31:0] RECIP_M     = 32'd2164392969;
	localparam int          RECIP_SHIFT = 38;

	localparam logic [7:0]  RUN_BYTE   = 8'h01;
	localparam logic [24:0] COUNT_ONE  = 25'd1;

	typedef enum logic {
		KIND_FULL  = 1'b0,
		KIND_DELTA = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        failed;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [24:0] repeat_count;
		logic        last_of_run;
		logic        table_failed;
	} res_t;

endpackage

/* rtl/rfte_fifo.sv */
// small register queue used between the front, the back and the result ports
module rfte_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/rfte_front.sv */
// front end: accepts items, classifies relocation types and keeps the offset state
module rfte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic [31:0]         reloc_offset,
	input  logic [7:0]          reloc_type,
	input  logic                cmd_full,
	output logic                cmd_push,
	output rfte_pkg::cmd_t      cmd
);

	logic [31:0] prev_q;
	logic        err_q;
	logic [31:0] prev_d;
	logic        err_d;
	logic        accept;
	logic        emit;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_push = accept && emit;

	always_comb begin
		emit       = 1'b0;
		cmd.kind   = rfte_pkg::KIND_FULL;
		cmd.value  = '0;
		cmd.failed = 1'b0;
		prev_d     = prev_q;
		err_d      = err_q;
		if (func == rfte_pkg::FUNC_END) begin
			emit       = 1'b1;
			cmd.kind   = (prev_q == '0) ? rfte_pkg::KIND_FULL : rfte_pkg::KIND_DELTA;
			cmd.failed = err_q;
			prev_d     = '0;
			err_d      = 1'b0;
		end else if (!err_q) begin
			case (reloc_type) inside
				rfte_pkg::TYPE_ABS32: begin
					emit = 1'b1;
					if (prev_q == '0) begin
						cmd.kind  = rfte_pkg::KIND_FULL;
						cmd.value = reloc_offset;
					end else begin
						cmd.kind  = rfte_pkg::KIND_DELTA;
						cmd.value = reloc_offset - prev_q;
					end
					prev_d = reloc_offset;
				end
				rfte_pkg::TYPE_NONE, rfte_pkg::TYPE_PC32,
				rfte_pkg::TYPE_PC16, rfte_pkg::TYPE_PC8: begin
					emit = 1'b0;
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			err_q  <= 1'b0;
		end else if (accept) begin
			prev_q <= prev_d;
			err_q  <= err_d;
		end
	end

endmodule

/* rtl/rfte_back.sv */
// back end: splits deltas into runs of 254 and sequences the result items
module rfte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  rfte_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output rfte_pkg::res_t      res
);

	localparam int QW = 25;

	rfte_pkg::cmd_t cmd_s1;
	rfte_pkg::cmd_t cmd_s2;
	rfte_pkg::cmd_t cmd_s3;
	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic           big_s1;
	logic           big_s2;
	logic           big_s3;
	logic [30:0]    y_s1;
	logic [62:0]    prod_s2;
	logic [QW-1:0]  q_s3;
	logic [1:0]     idx_q;
	logic           advance;
	logic [31:0]    dm1;
	logic [7:0]     rem;
	logic [4:0]     sh;

	assign dm1     = cmd.value - 32'd1;
	assign advance = !v_s3 || (res_push && res.last_of_run);
	assign cmd_pop = advance && !cmd_empty;
	assign rem     = cmd_s3.value[7:0] + {q_s3[6:0], 1'b0};
	assign sh      = {3'(2'd3 - idx_q), 2'b00} << 1;

	always_comb begin
		res.table_failed = cmd_s3.failed;
		res.repeat_count = rfte_pkg::COUNT_ONE;
		res.out_byte     = cmd_s3.value[7:0];
		res.last_of_run  = 1'b1;
		if (cmd_s3.kind == rfte_pkg::KIND_FULL) begin
			res.out_byte    = 8'(cmd_s3.value >> sh);
			res.last_of_run = (idx_q == 2'd3);
		end else if (big_s3) begin
			if (idx_q == 2'd0) begin
				res.out_byte     = rfte_pkg::RUN_BYTE;
				res.repeat_count = q_s3;
				res.last_of_run  = 1'b0;
			end else begin
				res.out_byte = rem;
			end
		end
	end

	assign res_push = v_s3 && !res_full;

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1  <= cmd;
			big_s1  <= (cmd.value > rfte_pkg::STEP_SIZE);
			y_s1    <= dm1[31:1];
			cmd_s2  <= cmd_s1;
			big_s2  <= big_s1;
			prod_s2 <= 63'(y_s1) * 63'(rfte_pkg::RECIP_M);
			cmd_s3  <= cmd_s2;
			big_s3  <= big_s2;
			q_s3    <= prod_s2[rfte_pkg::RECIP_SHIFT +: QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (advance) begin
				v_s1 <= !cmd_empty;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (res_push) begin
				idx_q <= res.last_of_run ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

/* rtl/relocation_fixup_table_encoder.sv */
// top level of the relocation fixup table encoder
// The front end accepts one item per cycle while its command queue has room; an absolute
// relocation or an end item becomes one command; other types emit none, and an unknown type
// sets the error flag. The back end runs each command through a three-stage divide-by-254
// pipeline (one 31x32 multiply by a reciprocal) and then writes one result item per cycle
// into the result queue while it has room; an item causes one to four results, and the back
// end takes a new command only after the last result of the current one is written.
module relocation_fixup_table_encoder #(
	parameter int CMD_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [31:0] reloc_offset,
	input  logic [7:0]  reloc_type,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [24:0] repeat_count,
	output logic        last_of_run,
	output logic        table_failed
);

	localparam int CMD_W = $bits(rfte_pkg::cmd_t);
	localparam int RES_W = $bits(rfte_pkg::res_t);

	rfte_pkg::cmd_t cmd_wr;
	rfte_pkg::cmd_t cmd_rd;
	rfte_pkg::res_t res_wr;
	rfte_pkg::res_t res_rd;
	logic           cmd_push;
	logic           cmd_full;
	logic           cmd_pop;
	logic           cmd_empty;
	logic           res_push;
	logic           res_full;

	rfte_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.reloc_offset (reloc_offset),
		.reloc_type   (reloc_type),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd          (cmd_wr)
	);

	rfte_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rd),
		.empty  (cmd_empty)
	);

	rfte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	rfte_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd),
		.empty  (empty)
	);

	assign out_byte     = res_rd.out_byte;
	assign repeat_count = res_rd.repeat_count;
	assign last_of_run  = res_rd.last_of_run;
	assign table_failed = res_rd.table_failed;

endmodule
